/* hw/rtl/gnms_pkg.sv */
package gnms_pkg;

  // defaults of the top level parameters
  localparam int MAX_CANDIDATES_DEF = 4096;
  localparam int MAX_DETECTIONS_DEF = 512;
  localparam int BLOCK_BITS_DEF     = 32;

  // fixed field widths
  localparam int COUNT_W = 13;
  localparam int ROW_W   = 12;
  localparam int BLOCK_W = 7;
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 9;
  localparam int KEPT_W  = 10;

  // own block of a row sized for the narrowest block (8 bits), bit inside it for a 32-bit block
  localparam int OWN_W = ROW_W - 3;
  localparam int POS_W = 5;

  // queue depths between front and back, and of the result buffer
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // classified mask word handed from front to back
  typedef struct packed {
    logic               start;
    logic               blk0;
    logic               row_ok;
    logic               blk_ok;
    logic [ROW_W-1:0]   row;
    logic [OWN_W-1:0]   own;
    logic [POS_W-1:0]   pos;
    logic [BLOCK_W-1:0] blk;
    logic [WORD_W-1:0]  word;
  } cmd_t;

  // one kept detection
  typedef struct packed {
    logic [ROW_W-1:0]  candidate_index;
    logic [SLOT_W-1:0] kept_slot;
  } res_t;

endpackage

/* hw/rtl/greedy_nms_mask_reduce_core.sv */
// Greedy mask-based suppression: takes one 32-bit overlap word per beat and sustains one beat
// per clock with both sides free-running; for a kept row the block-0 word goes through the
// command queue and the decide stage register into the result buffer, which drives out_tvalid.
// The front saturates the candidate count and classifies each word,
// a four-entry queue decouples it from the back, which keeps the suppressed bitmap in a memory
// with registered reads and forwards the last update, so consecutive words of one row, or rows
// that hit the same block, need no bubble. A start beat clears the bitmap at once through
// per-block valid bits, so there is no clearing pass. Results buffer in a four-entry queue, and
// the back stops pulling words only while that buffer could overflow.
module greedy_nms_mask_reduce_core #(
  parameter int MAX_CANDIDATES = gnms_pkg::MAX_CANDIDATES_DEF,
  parameter int MAX_DETECTIONS = gnms_pkg::MAX_DETECTIONS_DEF,
  parameter int BLOCK_BITS     = gnms_pkg::BLOCK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // cand_count, row_index, block_index, mask_word
  input  logic        in_tuser,   // start_batch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // kept_slot, candidate_index, zero fill
);

  localparam int NUM_BLOCKS = (MAX_CANDIDATES + BLOCK_BITS - 1) / BLOCK_BITS;
  localparam int ROW_BLOCKS = ((1 << gnms_pkg::ROW_W) + BLOCK_BITS - 1) / BLOCK_BITS;
  localparam int MEM_DEPTH  = (NUM_BLOCKS < ROW_BLOCKS) ? NUM_BLOCKS : ROW_BLOCKS;
  localparam int CMD_W      = $bits(gnms_pkg::cmd_t);
  localparam int RES_W      = $bits(gnms_pkg::res_t);

  logic                  in_fire;
  gnms_pkg::cmd_t        cmd_in, cmd_head;
  logic [CMD_W-1:0]      cmd_head_bits;
  logic                  cmd_empty, cmd_full, cmd_pop;
  logic [$clog2(gnms_pkg::CMD_DEPTH+1)-1:0] cmd_count;

  gnms_pkg::res_t        res_in, res_head;
  logic [RES_W-1:0]      res_head_bits;
  logic                  res_push, res_empty, res_full, res_pop;
  logic [$clog2(gnms_pkg::RES_DEPTH+1)-1:0] res_count;

  // input handshake
  assign in_tready = !cmd_full;
  assign in_fire   = in_tvalid && in_tready;

  gnms_front #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .BLOCK_BITS     (BLOCK_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_start (in_tuser),
    .in_count (in_tdata[12:0]),
    .in_row   (in_tdata[24:13]),
    .in_block (in_tdata[31:25]),
    .in_word  (in_tdata[63:32]),
    .cmd      (cmd_in)
  );

  // queue between front and back
  gnms_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (gnms_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .head      (cmd_head_bits),
    .empty     (cmd_empty),
    .full      (cmd_full),
    .count     (cmd_count)
  );

  assign cmd_head = gnms_pkg::cmd_t'(cmd_head_bits);

  gnms_back #(
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .BLOCK_BITS     (BLOCK_BITS),
    .MEM_DEPTH      (MEM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (cmd_empty),
    .q_head    (cmd_head),
    .q_pop     (cmd_pop),
    .res_count (res_count),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // result buffer
  gnms_fifo #(
    .WIDTH (RES_W),
    .DEPTH (gnms_pkg::RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (res_pop),
    .head      (res_head_bits),
    .empty     (res_empty),
    .full      (res_full),
    .count     (res_count)
  );

  // output beat
  assign res_head   = gnms_pkg::res_t'(res_head_bits);
  assign out_tvalid = !res_empty;
  assign res_pop    = out_tvalid && out_tready;
  assign out_tdata  = {3'b000, res_head.candidate_index, res_head.kept_slot};

  logic cmd_count_unused;
  assign cmd_count_unused = ^cmd_count;

endmodule

/* hw/rtl/gnms_fifo.sv */
module gnms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign count = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/gnms_front.sv */
module gnms_front #(
  parameter int MAX_CANDIDATES = gnms_pkg::MAX_CANDIDATES_DEF,
  parameter int BLOCK_BITS     = gnms_pkg::BLOCK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         in_start,
  input  logic [gnms_pkg::COUNT_W-1:0] in_count,
  input  logic [gnms_pkg::ROW_W-1:0]   in_row,
  input  logic [gnms_pkg::BLOCK_W-1:0] in_block,
  input  logic [gnms_pkg::WORD_W-1:0]  in_word,
  output gnms_pkg::cmd_t               cmd
);

  localparam int COUNT_MAX  = (1 << gnms_pkg::COUNT_W) - 1;
  localparam int CAP_I      = (MAX_CANDIDATES > COUNT_MAX) ? COUNT_MAX : MAX_CANDIDATES;
  localparam logic [gnms_pkg::COUNT_W-1:0] FC_CAP = gnms_pkg::COUNT_W'(CAP_I);
  localparam int NUM_BLOCKS = (MAX_CANDIDATES + BLOCK_BITS - 1) / BLOCK_BITS;
  // reciprocal of the block size, exact for 12-bit rows
  localparam int RSH        = 20;
  localparam int RECIP      = ((1 << RSH) + BLOCK_BITS - 1) / BLOCK_BITS;

  logic [gnms_pkg::COUNT_W-1:0] frame_count_r, frame_count_nxt;
  logic [gnms_pkg::COUNT_W-1:0] count_sat;
  logic [gnms_pkg::COUNT_W-1:0] fc;
  logic [31:0]                  own_prod;
  logic [gnms_pkg::OWN_W-1:0]   own;
  logic [gnms_pkg::ROW_W-1:0]   own_base;
  logic [31:0]                  blk_base;

  // frame count, saturated, taken on a start beat
  assign count_sat       = (in_count > FC_CAP) ? FC_CAP : in_count;
  assign fc              = in_start ? count_sat : frame_count_r;
  assign frame_count_nxt = (in_fire && in_start) ? count_sat : frame_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else begin
      frame_count_r <= frame_count_nxt;
    end
  end

  // own block and bit position of the row
  assign own_prod = 32'(in_row) * 32'(RECIP);
  assign own      = own_prod[RSH +: gnms_pkg::OWN_W];
  assign own_base = gnms_pkg::ROW_W'(32'(own) * 32'(BLOCK_BITS));
  assign blk_base = 32'(in_block) * 32'(BLOCK_BITS);

  // classify the beat
  always_comb begin
    cmd.start  = in_start;
    cmd.blk0   = (in_block == '0);
    cmd.row_ok = ({1'b0, in_row} < fc);
    cmd.blk_ok = (blk_base < 32'(fc)) && (32'(in_block) < 32'(NUM_BLOCKS)) &&
                 (32'(in_block) >= 32'(own));
    cmd.row    = in_row;
    cmd.own    = own;
    cmd.pos    = gnms_pkg::POS_W'(in_row - own_base);
    cmd.blk    = in_block;
    cmd.word   = in_word;
  end

endmodule

/* hw/rtl/gnms_back.sv */
module gnms_back #(
  parameter int MAX_DETECTIONS = gnms_pkg::MAX_DETECTIONS_DEF,
  parameter int BLOCK_BITS     = gnms_pkg::BLOCK_BITS_DEF,
  parameter int MEM_DEPTH      = 128
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_empty,
  input  gnms_pkg::cmd_t                              q_head,
  output logic                                        q_pop,
  input  logic [$clog2(gnms_pkg::RES_DEPTH+1)-1:0]    res_count,
  input  logic                                        res_full,
  output logic                                        res_push,
  output gnms_pkg::res_t                              res_data
);

  localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PBITS = $clog2(BLOCK_BITS);

  // suppressed-candidate bitmap, one row per block, valid bits stand for the clear
  logic [BLOCK_BITS-1:0] bitmap_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  valid_r, valid_nxt;

  logic                  s2_valid_r;
  gnms_pkg::cmd_t        s2_cmd_r;
  logic [BLOCK_BITS-1:0] rd_own_r, rd_blk_r;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [BLOCK_BITS-1:0] fwd_data_r;

  logic [gnms_pkg::KEPT_W-1:0] kept_r, kept_nxt, kept_base;
  logic                        keep_r, keep_nxt;

  logic [AW-1:0]         rd_own_addr, rd_blk_addr;
  logic [AW-1:0]         own_addr, blk_addr;
  logic [BLOCK_BITS-1:0] own_raw, blk_raw, own_val, blk_val;
  logic [PBITS-1:0]      pos;
  logic                  wr_en;
  logic [BLOCK_BITS-1:0] wr_data;

  // pop only while the result buffer has room for everything in flight
  assign q_pop = !q_empty &&
                 ((32'(res_count) + 32'(s2_valid_r)) < 32'(gnms_pkg::RES_DEPTH));

  assign rd_own_addr = q_head.own[AW-1:0];
  assign rd_blk_addr = AW'(q_head.blk);

  // bitmap memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap_mem[blk_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_own_r <= bitmap_mem[rd_own_addr];
      rd_blk_r <= bitmap_mem[rd_blk_addr];
    end
  end

  // decide stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      valid_r     <= '0;
      kept_r      <= '0;
      keep_r      <= 1'b0;
    end else begin
      s2_valid_r  <= q_pop;
      fwd_valid_r <= wr_en;
      valid_r     <= valid_nxt;
      kept_r      <= kept_nxt;
      keep_r      <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd_r <= q_head;
    end
    fwd_addr_r <= blk_addr;
    fwd_data_r <= wr_data;
  end

  // read data with forwarding of the last update and the clear mark
  assign own_addr = s2_cmd_r.own[AW-1:0];
  assign blk_addr = AW'(s2_cmd_r.blk);
  assign pos      = s2_cmd_r.pos[PBITS-1:0];
  assign own_raw  = (fwd_valid_r && fwd_addr_r == own_addr) ? fwd_data_r :
                    (valid_r[own_addr] ? rd_own_r : '0);
  assign blk_raw  = (fwd_valid_r && fwd_addr_r == blk_addr) ? fwd_data_r :
                    (valid_r[blk_addr] ? rd_blk_r : '0);
  assign own_val  = s2_cmd_r.start ? '0 : own_raw;
  assign blk_val  = s2_cmd_r.start ? '0 : blk_raw;
  assign wr_data  = blk_val | s2_cmd_r.word[BLOCK_BITS-1:0];

  // keep decision, counter and bitmap update
  always_comb begin
    kept_base = s2_cmd_r.start ? '0 : kept_r;
    kept_nxt  = kept_r;
    keep_nxt  = keep_r;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    res_push  = 1'b0;
    if (s2_valid_r) begin
      kept_nxt = kept_base;
      if (s2_cmd_r.start) begin
        keep_nxt  = 1'b0;
        valid_nxt = '0;
      end
      if (s2_cmd_r.blk0) begin
        keep_nxt = 1'b0;
        if (s2_cmd_r.row_ok && !own_val[pos] &&
            (32'(kept_base) < 32'(MAX_DETECTIONS))) begin
          res_push = 1'b1;
          kept_nxt = kept_base + 1'b1;
          keep_nxt = 1'b1;
        end
      end
      if (keep_nxt && s2_cmd_r.row_ok && s2_cmd_r.blk_ok) begin
        wr_en               = 1'b1;
        valid_nxt[blk_addr] = 1'b1;
      end
    end
  end

  assign res_data.kept_slot       = kept_base[gnms_pkg::SLOT_W-1:0];
  assign res_data.candidate_index = s2_cmd_r.row;

`ifndef NO_ASSERTIONS
  ap_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full buffer");

  ap_write_kept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> keep_r)
    else $error("bitmap updated by a row that is not kept");

  ap_kept_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (kept_r == $past(kept_base) + 1'b1))
    else $error("kept counter did not advance on a kept row");

  ap_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s2_valid_r)
    else $error("popped word did not reach the decide stage");
`endif

endmodule
